// ===== rtl/core/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the region mean-split threshold block.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int PIX_W       = 8;
	localparam int SUM_W       = 32;
	localparam int CNT_W       = 25;
	localparam int DIM_W       = 13;
	localparam int SPAN_W      = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int DIV_STEPS_W = $clog2(SUM_W + 1);

	localparam logic [DIV_STEPS_W-1:0] DIV_STEPS = DIV_STEPS_W'(SUM_W);
	localparam logic [PIX_W-1:0]       PIX_MAX   = '1;
	localparam logic [PIX_W-1:0]       PIX_MIN   = '0;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_INIT_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_SPAN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL_START  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COL_SPAN   = 3'd6;

	typedef struct packed {
		logic [PIX_W-1:0]  init_thr;
		logic [DIM_W-1:0]  frame_rows;
		logic [DIM_W-1:0]  frame_cols;
		logic [SPAN_W-1:0] row_start;
		logic [SPAN_W-1:0] row_span;
		logic [SPAN_W-1:0] col_start;
		logic [SPAN_W-1:0] col_span;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_MEASURE,
		ST_START_BACK,
		ST_WAIT_BACK,
		ST_START_FORE,
		ST_WAIT_FORE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic measure_en;
		logic apply_en;
		logic div_start;
		logic div_sel;    // 0: background class, 1: foreground class
		logic take_back;
		logic take_fore;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic div_busy;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/rmst_div.sv =====
// ----------------------------------------------------------------------------
// rmst_div
// Restoring divider, one quotient bit per cycle, for the class means.
// ----------------------------------------------------------------------------
module rmst_div
	import rmst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic [CNT_W:0]           rem_q;
	logic [SUM_W-1:0]         quo_q;
	logic [DIV_STEPS_W-1:0]   cnt_q;
	logic                     done_q;
	logic [CNT_W:0]           shifted;
	logic [CNT_W:0]           diff;
	logic                     ge;

	// remainder stays below the divisor, so the shifted value fits CNT_W+1 bits
	assign shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign ge      = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_STEPS_W'(1)) && !start;
			if (start) begin
				cnt_q <= DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_STEPS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff : shifted;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/rmst_dp.sv =====
// ----------------------------------------------------------------------------
// rmst_dp
// Datapath: raster position, region test, class sums, means, output register.
// ----------------------------------------------------------------------------
module rmst_dp
	import rmst_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  cmd_t             cmd,
	output status_t          status,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] pixel_in,
	input  logic             pass_last,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [PIX_W-1:0] pixel_out,
	output logic             frame_done,
	output logic [PIX_W-1:0] threshold_used,
	output logic             empty_class
);

	localparam int IDXW = $clog2(MAX_DIM);
	localparam int CMPW = (IDXW + 1 > DIM_W) ? IDXW + 1 : DIM_W;
	localparam logic [IDXW:0] DIM_LIM = (IDXW+1)'(MAX_DIM);

	logic [IDXW-1:0]  row_q, col_q;
	logic [IDXW:0]    next_row, next_col;
	logic             row_wrap, col_wrap;
	logic             in_region;
	logic             accept;

	logic [SUM_W-1:0] fore_sum_q, back_sum_q;
	logic [CNT_W-1:0] fore_cnt_q, back_cnt_q;
	logic [PIX_W-1:0] back_mean_q;
	logic [PIX_W-1:0] thr_q;
	logic             empty_q;

	logic [SUM_W-1:0] div_dividend;
	logic [CNT_W-1:0] div_divisor;
	logic [SUM_W-1:0] div_quotient;
	logic             div_busy, div_done;
	logic [PIX_W-1:0] mean;
	logic [PIX_W:0]   mean_sum;

	logic             out_valid_q;
	logic [PIX_W-1:0] pix_out_q;
	logic             last_q;
	logic [PIX_W-1:0] thr_out_q;
	logic             empty_out_q;

	assign accept = in_valid & cmd.in_ready;

	// raster position; indexes wrap at the frame size or at MAX_DIM, whichever is smaller
	assign next_col = {1'b0, col_q} + (IDXW+1)'(1);
	assign next_row = {1'b0, row_q} + (IDXW+1)'(1);
	assign col_wrap = (next_col >= DIM_LIM) || (CMPW'(next_col) >= CMPW'(cfg.frame_cols));
	assign row_wrap = (next_row >= DIM_LIM) || (CMPW'(next_row) >= CMPW'(cfg.frame_rows));

	assign in_region = (CMPW'(row_q) >= CMPW'(cfg.row_start)) &&
	                (CMPW'(row_q) <= CMPW'({1'b0, cfg.row_start} + {1'b0, cfg.row_span})) &&
	                (CMPW'(col_q) >= CMPW'(cfg.col_start)) &&
	                (CMPW'(col_q) <= CMPW'({1'b0, cfg.col_start} + {1'b0, cfg.col_span}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (pass_last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : next_row[IDXW-1:0];
			end else begin
				col_q <= next_col[IDXW-1:0];
			end
		end
	end

	// class accumulation, cleared once the new threshold is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_sum_q <= '0;
			back_sum_q <= '0;
			fore_cnt_q <= '0;
			back_cnt_q <= '0;
		end else if (cmd.take_fore) begin
			fore_sum_q <= '0;
			back_sum_q <= '0;
			fore_cnt_q <= '0;
			back_cnt_q <= '0;
		end else if (accept && cmd.measure_en && in_region) begin
			if (pixel_in > cfg.init_thr) begin
				fore_sum_q <= fore_sum_q + SUM_W'(pixel_in);
				fore_cnt_q <= fore_cnt_q + CNT_W'(1);
			end else begin
				back_sum_q <= back_sum_q + SUM_W'(pixel_in);
				back_cnt_q <= back_cnt_q + CNT_W'(1);
			end
		end
	end

	assign div_dividend = cmd.div_sel ? fore_sum_q : back_sum_q;
	assign div_divisor  = cmd.div_sel ? fore_cnt_q : back_cnt_q;

	rmst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// empty class reads as mean 0; means above full scale clip
	always_comb begin
		if (div_divisor == '0) begin
			mean = PIX_MIN;
		end else if (|div_quotient[SUM_W-1:PIX_W]) begin
			mean = PIX_MAX;
		end else begin
			mean = div_quotient[PIX_W-1:0];
		end
	end

	assign mean_sum = {1'b0, back_mean_q} + {1'b0, mean};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			empty_q <= 1'b0;
		end else if (cmd.take_back) begin
			empty_q <= (back_cnt_q == '0);
		end else if (cmd.take_fore) begin
			thr_q   <= mean_sum[PIX_W:1];
			empty_q <= empty_q | (fore_cnt_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_back) begin
			back_mean_q <= mean;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && cmd.apply_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.apply_en) begin
			if (in_region) begin
				pix_out_q <= (pixel_in > thr_q) ? PIX_MAX : PIX_MIN;
			end else begin
				pix_out_q <= pixel_in;
			end
			last_q      <= pass_last;
			thr_out_q   <= thr_q;
			empty_out_q <= empty_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_out      = pix_out_q;
	assign frame_done     = last_q;
	assign threshold_used = thr_out_q;
	assign empty_class    = empty_out_q;

	assign status.accept   = accept;
	assign status.last     = pass_last;
	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/core/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmst_ctrl
// Pass sequencer: measure pass, two mean divisions, apply pass.
// ----------------------------------------------------------------------------
module rmst_ctrl
	import rmst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MEASURE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_MEASURE: begin
				if (status.accept && status.last) state_d = ST_START_BACK;
			end
			ST_START_BACK: state_d = ST_WAIT_BACK;
			ST_WAIT_BACK: begin
				if (status.div_done) state_d = ST_START_FORE;
			end
			ST_START_FORE: state_d = ST_WAIT_FORE;
			ST_WAIT_FORE: begin
				if (status.div_done) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (status.accept && status.last) state_d = ST_MEASURE;
			end
			default: state_d = ST_MEASURE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_MEASURE: begin
				cmd.in_ready   = 1'b1;
				cmd.measure_en = 1'b1;
			end
			ST_START_BACK: begin
				cmd.div_start = 1'b1;
			end
			ST_WAIT_BACK: begin
				cmd.take_back = status.div_done;
			end
			ST_START_FORE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
			end
			ST_WAIT_FORE: begin
				cmd.div_sel   = 1'b1;
				cmd.take_fore = status.div_done;
			end
			ST_APPLY: begin
				cmd.in_ready = status.out_free;
				cmd.apply_en = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MEASURE && state_q != ST_APPLY) |-> !cmd.in_ready)
		else $error("input taken while means are computed");

	a_start_runs_divider: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> status.div_busy)
		else $error("divider did not start");

	a_measure_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEASURE && status.accept && status.last) |=> state_q == ST_START_BACK)
		else $error("measure pass end missed");

	a_fore_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_fore |=> (state_q == ST_APPLY && !status.div_busy))
		else $error("apply pass not entered after threshold update");
`endif

endmodule

// ===== rtl/core/roi_mean_split_threshold.sv =====
// ----------------------------------------------------------------------------
// roi_mean_split_threshold
// One mean-split threshold iteration over a rectangular region of a frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tdata: pixel_in; tlast: pass_last
// m_*       out        m_tvalid / m_tready   tdata: pixel_out, threshold_used;
//                                            tlast: frame_done; tuser: empty_class
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Measure pass: one pixel per cycle, no result. Apply pass: one pixel per
// cycle, one result each, held back only by m_tready through the output reg.
// After the last measure pixel the input stalls while two 32-step restoring
// divisions (background then foreground mean) run in one shared divider.
// Reset clears the pass state, sums, counts, threshold and output valid.
// Config writes are always taken (cfg_ready tied high).
//
module roi_mean_split_threshold
	import rmst_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] pixel_in
	input  logic                  s_tlast,   // pass_last
	// result output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [7:0] pixel_out, [15:8] threshold_used
	output logic                  m_tlast,   // frame_done
	output logic                  m_tuser,   // [0] empty_class
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	cmd_t             cmd;
	status_t          status;
	logic [PIX_W-1:0] pixel_out;
	logic [PIX_W-1:0] threshold_used;

	// register file; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_thr   <= 8'd128;
			cfg_q.frame_rows <= 13'd512;
			cfg_q.frame_cols <= 13'd512;
			cfg_q.row_start  <= '0;
			cfg_q.row_span   <= 12'd4095;
			cfg_q.col_start  <= '0;
			cfg_q.col_span   <= 12'd4095;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INIT_THR:   cfg_q.init_thr   <= cfg_data[PIX_W-1:0];
				REG_FRAME_ROWS: cfg_q.frame_rows <= cfg_data[DIM_W-1:0];
				REG_FRAME_COLS: cfg_q.frame_cols <= cfg_data[DIM_W-1:0];
				REG_ROW_START:  cfg_q.row_start  <= cfg_data[SPAN_W-1:0];
				REG_ROW_SPAN:   cfg_q.row_span   <= cfg_data[SPAN_W-1:0];
				REG_COL_START:  cfg_q.col_start  <= cfg_data[SPAN_W-1:0];
				REG_COL_SPAN:   cfg_q.col_span   <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	rmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// datapath with the mean divider and output register
	rmst_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.status         (status),
		.in_valid       (s_tvalid),
		.pixel_in       (s_tdata),
		.pass_last      (s_tlast),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.pixel_out      (pixel_out),
		.frame_done     (m_tlast),
		.threshold_used (threshold_used),
		.empty_class    (m_tuser)
	);

	assign s_tready = cmd.in_ready;
	assign m_tdata  = {threshold_used, pixel_out};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for roi_mean_split_threshold. Frames go through the
// pixel stream as a measure pass and then an apply pass. A shadow model of
// the region statistics predicts every binarized pixel, and each result is
// checked field by field as it leaves the block. Both stream sides idle at
// random. Register writes happen only between frames.
// ----------------------------------------------------------------------------
module tb;
	import rmst_pkg::*;

	localparam int unsigned MAX_DIM      = 4096;
	localparam int unsigned DRAIN_CYCLES = 80;    // two 32-step divisions plus slack
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unmapped, must be ignored

	typedef enum logic [1:0] {PIX_UNIFORM, PIX_FLAT, PIX_NEAR, PIX_EXTREME} pix_mode_t;

	// one pixel request waiting for the driver
	typedef struct {
		logic [7:0]  pix;
		logic        last;
		int unsigned idle;    // cycles to hold off before presenting it
	} pixel_req_t;

	// one expected result of the apply pass
	typedef struct packed {
		logic [7:0] pix;
		logic       done;
		logic [7:0] thr;
		logic       empty;
	} binarized_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // [7:0] pixel_in
	logic                  s_tlast   = 1'b0; // pass_last
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;          // [7:0] pixel_out, [15:8] threshold_used
	logic                  m_tlast;          // frame_done
	logic                  m_tuser;          // [0] empty_class
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pixel_req_t  pixel_queue[$];
	binarized_t  binarized_q[$];

	// shadow of the block: registers and pass statistics
	cfg_t        model_cfg;
	logic        apply_phase;
	logic [11:0] row_idx, col_idx;
	logic [31:0] fore_total, back_total;
	logic [24:0] fore_cnt, back_cnt;
	logic [7:0]  split_thr;
	logic        empty_flag;

	int unsigned pushed_total   = 0;
	int unsigned accepted_total = 0;
	int unsigned results_seen   = 0;
	int unsigned frames_done    = 0;
	int unsigned empty_frames   = 0;
	int unsigned fault_count    = 0;
	int unsigned idle_run       = 0;
	int unsigned ready_hold     = 0;
	bit          send_calm      = 1'b0;
	bit          ready_calm     = 1'b0;

	roi_mean_split_threshold #(.MAX_DIM(MAX_DIM)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t ns: %s", $time, what);
	endfunction

	// class mean with the empty-class rule: no pixels gives 0 and raises the flag
	function automatic logic [7:0] class_mean(input logic [31:0] total, input logic [24:0] cnt);
		logic [31:0] q;
		if (cnt == '0) begin
			empty_flag = 1'b1;
			return PIX_MIN;
		end
		q = total / 32'(cnt);
		return (q > 32'd255) ? PIX_MAX : q[7:0];
	endfunction

	// raster position; a size of 0 acts as 1, sizes above MAX_DIM wrap at MAX_DIM
	function automatic void next_position();
		int unsigned nc, nr;
		nc = col_idx + 1;
		if (nc >= model_cfg.frame_cols || nc >= MAX_DIM) begin
			nr = row_idx + 1;
			col_idx = '0;
			row_idx = (nr >= model_cfg.frame_rows || nr >= MAX_DIM) ? 12'd0 : nr[11:0];
		end else begin
			col_idx = nc[11:0];
		end
	endfunction

	// advance the shadow by one accepted pixel; apply-pass pixels queue a result
	function automatic void track_pixel(input logic [7:0] pix, input logic last);
		int unsigned row_hi, col_hi;
		logic        in_region;
		logic [7:0]  mb, mf;
		binarized_t  res;
		row_hi = model_cfg.row_start;
		row_hi += model_cfg.row_span;
		col_hi = model_cfg.col_start;
		col_hi += model_cfg.col_span;
		in_region = row_idx >= model_cfg.row_start && row_idx <= row_hi &&
			col_idx >= model_cfg.col_start && col_idx <= col_hi;
		if (!apply_phase) begin
			if (in_region) begin
				if (pix > model_cfg.init_thr) begin
					fore_total += pix;
					fore_cnt++;
				end else begin
					back_total += pix;
					back_cnt++;
				end
			end
			if (last) begin
				empty_flag = 1'b0;
				mb = class_mean(back_total, back_cnt);
				mf = class_mean(fore_total, fore_cnt);
				split_thr = 8'(({1'b0, mb} + {1'b0, mf}) >> 1);
				fore_total = '0;
				back_total = '0;
				fore_cnt = '0;
				back_cnt = '0;
				row_idx = '0;
				col_idx = '0;
				apply_phase = 1'b1;
			end else begin
				next_position();
			end
			return;
		end
		res.pix = in_region ? ((pix > split_thr) ? PIX_MAX : PIX_MIN) : pix;
		res.done = last;
		res.thr = split_thr;
		res.empty = empty_flag;
		binarized_q.push_back(res);
		if (last) begin
			row_idx = '0;
			col_idx = '0;
			apply_phase = 1'b0;
		end else begin
			next_position();
		end
	endfunction

	// pixel driver: presents queued requests, holding off each for its idle count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			idle_run = 0;
		end else if (!s_tvalid || s_tready) begin
			if (pixel_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_run < pixel_queue[0].idle) begin
				s_tvalid <= 1'b0;
				idle_run++;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_queue[0].pix;
				s_tlast <= pixel_queue[0].last;
				void'(pixel_queue.pop_front());
				idle_run = 0;
			end
		end
	end

	// monitor: predicts from accepted pixels, then checks accepted results and
	// throttles m_tready. Prediction runs first so a same-edge result still finds
	// its expectation.
	always @(posedge clk or negedge arst_n) begin
		binarized_t exp_res;
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_hold = 0;
			model_cfg = '{init_thr: 8'd128, frame_rows: 13'd512, frame_cols: 13'd512,
				row_start: 12'd0, row_span: 12'd4095, col_start: 12'd0, col_span: 12'd4095};
			apply_phase = 1'b0;
			row_idx = '0;
			col_idx = '0;
			fore_total = '0;
			back_total = '0;
			fore_cnt = '0;
			back_cnt = '0;
			split_thr = '0;
			empty_flag = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_total++;
				track_pixel(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tlast) begin
					frames_done++;
					if (m_tuser)
						empty_frames++;
				end
				if (binarized_q.size() == 0) begin
					note_fault($sformatf("result with nothing expected: pix %0d thr %0d done %b empty %b",
						m_tdata[7:0], m_tdata[15:8], m_tlast, m_tuser));
				end else begin
					exp_res = binarized_q.pop_front();
					if (m_tdata[7:0] !== exp_res.pix || m_tdata[15:8] !== exp_res.thr ||
						m_tlast !== exp_res.done || m_tuser !== exp_res.empty)
						note_fault($sformatf({"mismatch pix exp %0d got %0d, thr exp %0d got %0d, ",
							"done exp %b got %b, empty exp %b got %b"},
							exp_res.pix, m_tdata[7:0], exp_res.thr, m_tdata[15:8],
							exp_res.done, m_tlast, exp_res.empty, m_tuser));
				end
				ready_hold = ready_calm ? 0 : $urandom_range(0, 5);
			end else if (ready_hold != 0) begin
				ready_hold--;
			end
			m_tready <= (ready_hold == 0);
		end
	end

	// one register write; called at a rising edge, returns at the edge that takes it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		case (idx)
			REG_INIT_THR:   model_cfg.init_thr = val[7:0];
			REG_FRAME_ROWS: model_cfg.frame_rows = val;
			REG_FRAME_COLS: model_cfg.frame_cols = val;
			REG_ROW_START:  model_cfg.row_start = val[11:0];
			REG_ROW_SPAN:   model_cfg.row_span = val[11:0];
			REG_COL_START:  model_cfg.col_start = val[11:0];
			REG_COL_SPAN:   model_cfg.col_span = val[11:0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(input logic [7:0] pix, input logic last);
		pixel_req_t req;
		req.pix = pix;
		req.last = last;
		req.idle = send_calm ? 0 : $urandom_range(0, 5);
		pixel_queue.push_back(req);
		pushed_total++;
	endtask

	// one pass of n pixels, pass_last on the final one
	task automatic queue_pass(input int unsigned n, input pix_mode_t mode, input logic [7:0] anchor);
		int          v;
		logic [7:0]  p;
		for (int unsigned i = 0; i < n; i++) begin
			case (mode)
				PIX_FLAT:    p = anchor;
				PIX_NEAR: begin
					v = int'(anchor) + int'($urandom_range(0, 6)) - 3;
					p = (v < 0) ? PIX_MIN : (v > 255) ? PIX_MAX : v[7:0];
				end
				PIX_EXTREME: p = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
				default:     p = 8'($urandom_range(0, 255));
			endcase
			push_pixel(p, i == n - 1);
		end
	endtask

	// pass length: up to 48 mostly whole, some cut short or overlong; else 1-48
	function automatic int unsigned pass_length(input int unsigned full);
		if (full > 48)
			return $urandom_range(1, 48);
		case ($urandom_range(0, 7))
			0:       return $urandom_range(1, full);
			1:       return full + $urandom_range(1, 5);
			default: return full;
		endcase
	endfunction

	// hold the sender until every request is taken and every result is back,
	// then let the block settle; ends at a rising edge
	task automatic drain();
		while (accepted_total != pushed_total || binarized_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned random_base, er, ec;
		pix_mode_t   mode;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values; an unmapped index must change nothing.
		// Early pass_last on a 512x512 frame.
		write_reg(REG_NONE, 13'h1fff);
		cfg_valid <= 1'b0;
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd128, 1'b0);
		push_pixel(8'd129, 1'b1);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd128, 1'b0);
		push_pixel(8'd129, 1'b1);
		drain();

		// top threshold: nothing can be foreground, so that class is empty
		write_reg(REG_INIT_THR, 13'd255);
		write_reg(REG_FRAME_ROWS, 13'd1);
		write_reg(REG_FRAME_COLS, 13'd3);
		write_reg(REG_ROW_START, 13'd0);
		write_reg(REG_ROW_SPAN, 13'd4095);
		write_reg(REG_COL_START, 13'd0);
		write_reg(REG_COL_SPAN, 13'd4095);
		cfg_valid <= 1'b0;
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd7, 1'b0);
		push_pixel(8'd200, 1'b1);
		push_pixel(8'd76, 1'b0);
		push_pixel(8'd77, 1'b0);
		push_pixel(8'd78, 1'b1);
		drain();

		// single-pixel region at (1,1), zero threshold, measure pass one past the
		// frame so the position wraps back to (0,0)
		write_reg(REG_INIT_THR, 13'd0);
		write_reg(REG_FRAME_ROWS, 13'd2);
		write_reg(REG_FRAME_COLS, 13'd2);
		write_reg(REG_ROW_START, 13'd1);
		write_reg(REG_ROW_SPAN, 13'd0);
		write_reg(REG_COL_START, 13'd1);
		write_reg(REG_COL_SPAN, 13'd0);
		cfg_valid <= 1'b0;
		push_pixel(8'd9, 1'b0);
		push_pixel(8'd200, 1'b0);
		push_pixel(8'd4, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd77, 1'b1);
		push_pixel(8'd3, 1'b0);
		push_pixel(8'd1, 1'b0);
		push_pixel(8'd250, 1'b0);
		push_pixel(8'd1, 1'b1);
		drain();

		// random frames: fresh registers, mostly whole passes with random content
		random_base = pushed_total;
		while (pushed_total - random_base < 500) begin
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0:       write_reg(REG_INIT_THR, 13'd0);
					1:       write_reg(REG_INIT_THR, 13'd255);
					default: write_reg(REG_INIT_THR, 13'($urandom_range(0, 255)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 6))
					0:       write_reg(REG_FRAME_ROWS, 13'd0);
					1:       write_reg(REG_FRAME_ROWS, 13'd4096);
					2:       write_reg(REG_FRAME_ROWS, 13'd8191);
					default: write_reg(REG_FRAME_ROWS, 13'($urandom_range(1, 6)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 6))
					0:       write_reg(REG_FRAME_COLS, 13'd0);
					1:       write_reg(REG_FRAME_COLS, 13'd4096);
					2:       write_reg(REG_FRAME_COLS, 13'd8191);
					default: write_reg(REG_FRAME_COLS, 13'($urandom_range(1, 6)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0:       write_reg(REG_ROW_START, 13'd0);
					1:       write_reg(REG_ROW_START, 13'd4095);
					default: write_reg(REG_ROW_START, 13'($urandom_range(0, 4)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0:       write_reg(REG_ROW_SPAN, 13'd0);
					1:       write_reg(REG_ROW_SPAN, 13'd4095);
					default: write_reg(REG_ROW_SPAN, 13'($urandom_range(0, 3)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0:       write_reg(REG_COL_START, 13'd0);
					1:       write_reg(REG_COL_START, 13'd4095);
					default: write_reg(REG_COL_START, 13'($urandom_range(0, 4)));
				endcase
			if ($urandom_range(0, 2) != 0)
				case ($urandom_range(0, 3))
					0:       write_reg(REG_COL_SPAN, 13'd0);
					1:       write_reg(REG_COL_SPAN, 13'd4095);
					default: write_reg(REG_COL_SPAN, 13'($urandom_range(0, 3)));
				endcase
			cfg_valid <= 1'b0;

			send_calm = ($urandom_range(0, 3) == 0);
			ready_calm = ($urandom_range(0, 3) == 0);
			er = (model_cfg.frame_rows == 0) ? 1 :
				(model_cfg.frame_rows > MAX_DIM) ? MAX_DIM : model_cfg.frame_rows;
			ec = (model_cfg.frame_cols == 0) ? 1 :
				(model_cfg.frame_cols > MAX_DIM) ? MAX_DIM : model_cfg.frame_cols;
			mode = pix_mode_t'($urandom_range(0, 3));
			queue_pass(pass_length(er * ec), mode, model_cfg.init_thr);
			queue_pass(pass_length(er * ec), mode, model_cfg.init_thr);
			drain();
		end

		if (binarized_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", binarized_q.size()));
		$display("covered %0d pixels in, %0d results checked over %0d frames",
			accepted_total, results_seen, frames_done);
		$display("%0d frames hit an empty class; %0d faults counted",
			empty_frames, fault_count);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rmst_pkg.sv
rtl/core/rmst_div.sv
rtl/core/rmst_dp.sv
rtl/core/rmst_ctrl.sv
rtl/core/roi_mean_split_threshold.sv
tb/tb.sv
